// ===== rtl/nfcs_pkg.sv =====
`default_nettype none

package nfcs_pkg;

	localparam int unsigned INFO_BYTES_DEFAULT = 256;
	localparam int unsigned CFG_DATA_W = 6;

	// configuration register indexes
	localparam logic [0:0] REG_DEVICE_MODE = 1'b0;
	localparam logic [0:0] REG_PAGE_COUNT  = 1'b1;

	localparam logic [1:0] DEVICE_MODE_RESET = 2'd0;
	localparam logic [5:0] PAGE_COUNT_RESET  = 6'd32;

	// device modes
	localparam logic [1:0] MODE_SECTOR_2K = 2'd0;
	localparam logic [1:0] MODE_AUTO      = 2'd1;

	// bus addresses of the command protocol
	localparam logic [15:0] ADDR_CMD_LO  = 16'h5555;
	localparam logic [15:0] ADDR_CMD_HI  = 16'hD555;
	localparam logic [15:0] ADDR_UNLOCK  = 16'hAAAA;
	localparam logic [15:0] ADDR_ID_MAKER = 16'h8000;
	localparam logic [15:0] ADDR_ID_PART  = 16'h8001;
	localparam logic [15:0] MASK_SECTOR_2K = 16'hF800;
	localparam logic [15:0] MASK_SECTOR_4K = 16'hF000;

	// data bytes of the command protocol
	localparam logic [7:0] DATA_UNLOCK_A  = 8'hAA;
	localparam logic [7:0] DATA_UNLOCK_B  = 8'h55;
	localparam logic [7:0] CMD_IDENT      = 8'h90;
	localparam logic [7:0] CMD_PROG       = 8'hA0;
	localparam logic [7:0] CMD_ERASE      = 8'h80;
	localparam logic [7:0] CMD_INFO_PROG  = 8'hA8;
	localparam logic [7:0] CMD_INFO_ERASE = 8'h88;
	localparam logic [7:0] CMD_INFO_READ  = 8'h78;
	localparam logic [7:0] CMD_POLL       = 8'h70;
	localparam logic [7:0] CMD_RESET      = 8'hF0;
	localparam logic [7:0] CONFIRM_CHIP   = 8'h10;
	localparam logic [7:0] CONFIRM_SECTOR = 8'h30;

	// bytes returned on reads
	localparam logic [7:0] STATUS_BUSY  = 8'h88;
	localparam logic [7:0] ID_MAKER_AUTO = 8'hBF;
	localparam logic [7:0] ID_MAKER_STD  = 8'hC7;
	localparam logic [7:0] ID_PART       = 8'hD7;
	localparam logic [7:0] ERASED_BYTE   = 8'hFF;

	// info block reset image: file table, then erased bytes, then zeros
	localparam logic [15:0] INFO_FILE_LEN  = 16'd19;
	localparam logic [15:0] INFO_TABLE_LEN = 16'd39;

	typedef enum logic [2:0] {
		SEQ_IDLE       = 3'd0,
		SEQ_UNLOCK_A   = 3'd1,
		SEQ_UNLOCK_B   = 3'd2,
		SEQ_ACTIVE     = 3'd3,
		SEQ_PROGRAMMED = 3'd4,	// program done, or second AA of an erase
		SEQ_ERASE_55   = 3'd5,
		SEQ_ERASING    = 3'd6
	} seq_t;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_IDENT      = 3'd1,
		KIND_PROG       = 3'd2,
		KIND_ERASE      = 3'd3,
		KIND_INFO_PROG  = 3'd4,
		KIND_INFO_ERASE = 3'd5,
		KIND_INFO_READ  = 3'd6,
		KIND_POLL       = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE         = 2'd0,
		ACT_PROGRAM      = 2'd1,
		ACT_SECTOR_ERASE = 2'd2,
		ACT_CHIP_ERASE   = 2'd3
	} action_t;

	// info store control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic erase;
	} info_ctl_t;

	function automatic logic [7:0] info_reset_byte(input logic [15:0] idx);
		logic [7:0] b;
		case (idx)
			16'd0:   b = 8'hBD;
			16'd1:   b = 8'hF0;
			16'd2:   b = 8'hD4;
			16'd3:   b = 8'hB6;
			16'd4:   b = 8'hBC;
			16'd5:   b = 8'hFB;
			16'd6:   b = 8'h4E;
			16'd7:   b = 8'h43;
			16'd8:   b = 8'hD0;
			16'd9:   b = 8'h07;
			16'd10:  b = 8'h4A;
			16'd11:  b = 8'h01;
			16'd12:  b = 8'h02;
			16'd13:  b = 8'h03;
			16'd14:  b = 8'h04;
			16'd15:  b = 8'h01;
			16'd16:  b = 8'h01;
			16'd17:  b = 8'h01;
			16'd18:  b = 8'h01;
			default: b = (idx < INFO_TABLE_LEN) ? ERASED_BYTE : 8'h00;
		endcase
		return b;
	endfunction

	function automatic kind_t decode_cmd(input logic [7:0] d);
		kind_t k;
		unique case (d)
			CMD_IDENT:      k = KIND_IDENT;
			CMD_PROG:       k = KIND_PROG;
			CMD_ERASE:      k = KIND_ERASE;
			CMD_INFO_PROG:  k = KIND_INFO_PROG;
			CMD_INFO_ERASE: k = KIND_INFO_ERASE;
			CMD_INFO_READ:  k = KIND_INFO_READ;
			CMD_POLL:       k = KIND_POLL;
			default:        k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nfcs_req_if.sv =====
`default_nettype none

interface nfcs_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        in_flash_window;
	logic [7:0]  bank_index;

	modport source (
		output valid, command, address, write_data, in_flash_window, bank_index,
		input  ready
	);
	modport sink (
		input  valid, command, address, write_data, in_flash_window, bank_index,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/nfcs_rsp_if.sv =====
`default_nettype none

interface nfcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        read_hit;
	logic        write_taken;
	logic [1:0]  array_action;
	logic [15:0] action_address;
	logic [7:0]  action_data;
	logic        sequence_error;

	modport source (
		output valid, read_data, read_hit, write_taken, array_action, action_address,
			action_data, sequence_error,
		input  ready
	);
	modport sink (
		input  valid, read_data, read_hit, write_taken, array_action, action_address,
			action_data, sequence_error,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/nfcs_info_store.sv =====
`default_nettype none

// Info block RAM with a fill sweep: reset image after reset, erased bytes on erase.
module nfcs_info_store #(
	parameter int unsigned INFO_BYTES = nfcs_pkg::INFO_BYTES_DEFAULT,
	localparam int unsigned IDX_W = $clog2(INFO_BYTES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nfcs_pkg::info_ctl_t    ctl,
	input  logic [IDX_W-1:0]       rd_idx,
	input  logic [IDX_W-1:0]       wr_idx,
	input  logic [7:0]             wr_data,
	output logic [7:0]             rd_data,
	output logic                   busy
);

	logic [7:0]       mem [INFO_BYTES];
	logic             busy_q;
	logic             fill_q;	// 1: erase sweep, 0: reset image
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       sweep_byte;

	assign busy = busy_q;
	assign sweep_byte = fill_q ? nfcs_pkg::ERASED_BYTE : nfcs_pkg::info_reset_byte(16'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			fill_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == IDX_W'(INFO_BYTES - 1)) busy_q <= 1'b0;
			cnt_q <= cnt_q + IDX_W'(1);
		end else if (ctl.erase) begin
			busy_q <= 1'b1;
			fill_q <= 1'b1;
			cnt_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[cnt_q] <= sweep_byte;
		end else if (ctl.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/nor_flash_command_sequencer_core.sv =====
`default_nettype none

// NOR flash command sequencer. Each word on req is one CPU bus access (read or write);
// each produces exactly one word on rsp, in order. Writes in the flash window walk the
// JEDEC unlock sequence (AA to 5555/D555, 55 to AAAA, command byte) and report array
// actions: byte program (AND), sector erase (2K in mode 0, 4K otherwise) and whole-array
// erase. The INFO_BYTES info block lives in a synchronous RAM with separate read and
// write ports inside the block and is programmed and erased here; reads in the window
// may be answered with the ID bytes, info data or busy status 0x88 (read_hit set).
// Throughput is one word per clock unless rsp.ready is low or an info RAM fill holds
// the words; three stages (quotient stage, RAM read, output register), a shape set by
// the info RAM's single read port; a one-entry bypass covers back-to-back info programs
// to the same byte. After reset the RAM is loaded with its reset image, one byte a clock,
// so req.ready stays low until it is loaded; an info erase refills the RAM the same way
// and holds off the following words until done. Configuration (device_mode, index 0;
// page_count, index 1) is written through cfg_we/cfg_index/cfg_data while idle.
module nor_flash_command_sequencer_core #(
	parameter int unsigned INFO_BYTES = nfcs_pkg::INFO_BYTES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nfcs_req_if.sink                      req,
	nfcs_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [nfcs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IDX_W     = $clog2(INFO_BYTES);
	// address / INFO_BYTES as multiply by reciprocal; exact for 16-bit addresses
	localparam int unsigned QUO_SHIFT = 16 + IDX_W;
	localparam longint unsigned QUO_MULT =
		((64'd1 << QUO_SHIFT) + 64'(INFO_BYTES) - 64'd1) / 64'(INFO_BYTES);

	typedef struct packed {
		logic        command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        in_flash_window;
		logic [7:0]  bank_index;
		logic [15:0] quot;
	} s0_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              read_hit;
		logic              write_taken;
		nfcs_pkg::action_t action;
		logic [15:0]       action_address;
		logic [7:0]        action_data;
		logic              sequence_error;
		logic              info_rd;	// read data comes from the info RAM
		logic              info_wr;	// AND write_data into info byte
		logic              erase;	// refill info RAM with erased bytes
		logic [7:0]        write_data;
	} s1_t;

	// ---- configuration ----
	logic [1:0] device_mode_q;
	logic [5:0] page_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_mode_q <= nfcs_pkg::DEVICE_MODE_RESET;
			page_count_q  <= nfcs_pkg::PAGE_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nfcs_pkg::REG_DEVICE_MODE: device_mode_q <= cfg_data[1:0];
				nfcs_pkg::REG_PAGE_COUNT:  page_count_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ---- pipeline control ----
	logic s0_v_q, s1_v_q, rsp_v_q;
	logic s0_adv, s1_adv, req_acc;
	logic mem_busy;
	s0_t  s0_q;
	s1_t  s1_q, s1_d;
	logic [IDX_W-1:0] idx_s1, s0_idx;
	logic fwd_s1;
	logic [7:0] fwd_data_s1;
	logic [7:0] mem_rd_data, info_cur, info_new;

	assign s1_adv  = s1_v_q && (!rsp_v_q || rsp.ready);
	// the word behind an info erase waits for the refill
	assign s0_adv  = s0_v_q && !mem_busy && (!s1_v_q || s1_adv) && !(s1_v_q && s1_q.erase);
	assign req.ready = !mem_busy && (!s0_v_q || s0_adv);
	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_v_q  <= 1'b0;
			s1_v_q  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (req_acc) s0_v_q <= 1'b1;
			else if (s0_adv) s0_v_q <= 1'b0;
			if (s0_adv) s1_v_q <= 1'b1;
			else if (s1_adv) s1_v_q <= 1'b0;
			if (s1_adv) rsp_v_q <= 1'b1;
			else if (rsp.ready) rsp_v_q <= 1'b0;
		end
	end

	// ---- stage 0 entry: quotient of address by INFO_BYTES ----
	logic [32:0] quot_prod;
	assign quot_prod = {17'd0, req.address} * 33'(QUO_MULT);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			s0_q.command         <= req.command;
			s0_q.address         <= req.address;
			s0_q.write_data      <= req.write_data;
			s0_q.in_flash_window <= req.in_flash_window;
			s0_q.bank_index      <= req.bank_index;
			s0_q.quot            <= 16'(quot_prod >> QUO_SHIFT);
		end
	end

	// ---- stage 0: info index and sequence decode ----
	logic [15:0] idx_rem;
	assign idx_rem = s0_q.address - 16'(s0_q.quot * 16'(INFO_BYTES));
	assign s0_idx  = idx_rem[IDX_W-1:0];

	nfcs_pkg::seq_t  step_q, step_nx;
	nfcs_pkg::kind_t kind_q, kind_nx, cmd_kind;
	logic at_cmd, at_unlock, is_erase_kind, auto_ret, wr_ok, done, finish;
	logic m_unlock1, m_unlock2, m_cmd, m_prog, m_iprog, m_eu1, m_eu2;
	logic m_chip, m_sect, m_isect;

	assign at_cmd    = (s0_q.address == nfcs_pkg::ADDR_CMD_LO) ||
	                   (s0_q.address == nfcs_pkg::ADDR_CMD_HI);
	assign at_unlock = (s0_q.address == nfcs_pkg::ADDR_UNLOCK) &&
	                   (s0_q.write_data == nfcs_pkg::DATA_UNLOCK_B);
	assign cmd_kind  = nfcs_pkg::decode_cmd(s0_q.write_data);
	assign is_erase_kind = (kind_q == nfcs_pkg::KIND_ERASE) ||
	                       (kind_q == nfcs_pkg::KIND_INFO_ERASE);
	assign auto_ret  = (device_mode_q == nfcs_pkg::MODE_AUTO);
	// a write that counts: in the window and in a populated bank
	assign wr_ok = s0_q.in_flash_window && s0_q.command &&
	               (s0_q.bank_index < {2'b00, page_count_q});

	assign m_unlock1 = (step_q == nfcs_pkg::SEQ_IDLE) && at_cmd &&
	                   (s0_q.write_data == nfcs_pkg::DATA_UNLOCK_A);
	assign m_unlock2 = (step_q == nfcs_pkg::SEQ_UNLOCK_A) && at_unlock;
	assign m_cmd     = (step_q == nfcs_pkg::SEQ_UNLOCK_B) && at_cmd &&
	                   (cmd_kind != nfcs_pkg::KIND_NONE);
	assign m_prog    = (step_q == nfcs_pkg::SEQ_ACTIVE) && (kind_q == nfcs_pkg::KIND_PROG);
	assign m_iprog   = (step_q == nfcs_pkg::SEQ_ACTIVE) &&
	                   (kind_q == nfcs_pkg::KIND_INFO_PROG);
	assign m_eu1     = (step_q == nfcs_pkg::SEQ_ACTIVE) && is_erase_kind && at_cmd &&
	                   (s0_q.write_data == nfcs_pkg::DATA_UNLOCK_A);
	assign m_eu2     = (step_q == nfcs_pkg::SEQ_PROGRAMMED) && is_erase_kind && at_unlock;
	assign m_chip    = (step_q == nfcs_pkg::SEQ_ERASE_55) && is_erase_kind && at_cmd &&
	                   (s0_q.write_data == nfcs_pkg::CONFIRM_CHIP);
	assign m_sect    = (step_q == nfcs_pkg::SEQ_ERASE_55) && !m_chip &&
	                   (kind_q == nfcs_pkg::KIND_ERASE) &&
	                   (s0_q.write_data == nfcs_pkg::CONFIRM_SECTOR);
	assign m_isect   = (step_q == nfcs_pkg::SEQ_ERASE_55) && !m_chip &&
	                   (kind_q == nfcs_pkg::KIND_INFO_ERASE) &&
	                   (s0_q.write_data == nfcs_pkg::CONFIRM_SECTOR);
	assign finish    = m_prog || m_iprog || m_chip || m_sect || m_isect;
	assign done      = m_unlock1 || m_unlock2 || m_cmd || m_eu1 || m_eu2 || finish;

	// next state
	always_comb begin
		step_nx = step_q;
		kind_nx = kind_q;
		if (wr_ok) begin
			unique case (step_q)
				nfcs_pkg::SEQ_IDLE: begin
					if (m_unlock1) step_nx = nfcs_pkg::SEQ_UNLOCK_A;
				end
				nfcs_pkg::SEQ_UNLOCK_A: begin
					if (m_unlock2) step_nx = nfcs_pkg::SEQ_UNLOCK_B;
				end
				nfcs_pkg::SEQ_UNLOCK_B: begin
					if (at_cmd) kind_nx = cmd_kind;
					if (m_cmd) step_nx = nfcs_pkg::SEQ_ACTIVE;
				end
				nfcs_pkg::SEQ_ACTIVE: begin
					if (m_prog || m_iprog) step_nx = nfcs_pkg::SEQ_PROGRAMMED;
					else if (m_eu1) step_nx = nfcs_pkg::SEQ_PROGRAMMED;
				end
				nfcs_pkg::SEQ_PROGRAMMED: begin
					if (m_eu2) step_nx = nfcs_pkg::SEQ_ERASE_55;
				end
				nfcs_pkg::SEQ_ERASE_55: begin
					if (m_chip || m_sect || m_isect) step_nx = nfcs_pkg::SEQ_ERASING;
				end
				default: ;
			endcase
			// auto-return mode drops straight back to idle after program or erase
			if (finish && auto_ret) begin
				step_nx = nfcs_pkg::SEQ_IDLE;
				kind_nx = nfcs_pkg::KIND_NONE;
			end
			if (!done && (s0_q.write_data == nfcs_pkg::CMD_RESET)) begin
				step_nx = nfcs_pkg::SEQ_IDLE;
				kind_nx = nfcs_pkg::KIND_NONE;
			end
		end
	end

	// result of this word, bar the info RAM data
	always_comb begin
		s1_d = '0;
		s1_d.action = nfcs_pkg::ACT_NONE;
		s1_d.write_data = s0_q.write_data;
		if (s0_q.in_flash_window && !s0_q.command) begin
			if ((kind_q == nfcs_pkg::KIND_INFO_READ) && (step_q == nfcs_pkg::SEQ_ACTIVE)) begin
				s1_d.info_rd  = 1'b1;
				s1_d.read_hit = 1'b1;
			end else if ((kind_q == nfcs_pkg::KIND_IDENT) &&
			             (step_q == nfcs_pkg::SEQ_ACTIVE)) begin
				if (s0_q.address == nfcs_pkg::ADDR_ID_MAKER) begin
					s1_d.read_data = auto_ret ? nfcs_pkg::ID_MAKER_AUTO : nfcs_pkg::ID_MAKER_STD;
					s1_d.read_hit  = 1'b1;
				end else if (s0_q.address == nfcs_pkg::ADDR_ID_PART) begin
					s1_d.read_data = nfcs_pkg::ID_PART;
					s1_d.read_hit  = 1'b1;
				end
			end else if (((kind_q == nfcs_pkg::KIND_POLL) &&
			              (step_q == nfcs_pkg::SEQ_ACTIVE)) ||
			             ((kind_q == nfcs_pkg::KIND_PROG) &&
			              (step_q == nfcs_pkg::SEQ_PROGRAMMED)) ||
			             ((kind_q == nfcs_pkg::KIND_ERASE) &&
			              (step_q == nfcs_pkg::SEQ_ERASING))) begin
				s1_d.read_data = nfcs_pkg::STATUS_BUSY;
				s1_d.read_hit  = 1'b1;
			end
		end else if (s0_q.in_flash_window && s0_q.command) begin
			s1_d.write_taken = 1'b1;
			if (wr_ok) begin
				if (m_prog) begin
					s1_d.action         = nfcs_pkg::ACT_PROGRAM;
					s1_d.action_address = s0_q.address;
					s1_d.action_data    = s0_q.write_data;
				end
				if (m_iprog) s1_d.info_wr = 1'b1;
				if (m_chip) begin
					s1_d.action = nfcs_pkg::ACT_CHIP_ERASE;
					s1_d.erase  = (kind_q == nfcs_pkg::KIND_INFO_ERASE);
				end
				if (m_sect) begin
					s1_d.action = nfcs_pkg::ACT_SECTOR_ERASE;
					s1_d.action_address = s0_q.address &
						((device_mode_q == nfcs_pkg::MODE_SECTOR_2K) ?
						 nfcs_pkg::MASK_SECTOR_2K : nfcs_pkg::MASK_SECTOR_4K);
				end
				if (m_isect) s1_d.erase = 1'b1;
				if (!done && (s0_q.write_data != nfcs_pkg::CMD_RESET))
					s1_d.sequence_error = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nfcs_pkg::SEQ_IDLE;
			kind_q <= nfcs_pkg::KIND_NONE;
		end else if (s0_adv) begin
			step_q <= step_nx;
			kind_q <= kind_nx;
		end
	end

	// ---- info RAM ----
	nfcs_pkg::info_ctl_t mem_ctl;
	assign mem_ctl.rd_en = s0_adv;
	assign mem_ctl.wr_en = s1_adv && s1_q.info_wr;
	assign mem_ctl.erase = s1_adv && s1_q.erase;

	nfcs_info_store #(
		.INFO_BYTES (INFO_BYTES)
	) u_info (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_idx  (s0_idx),
		.wr_idx  (idx_s1),
		.wr_data (info_new),
		.rd_data (mem_rd_data),
		.busy    (mem_busy)
	);

	// ---- stage 1: RAM data, bypass, read-modify-write ----
	// bypass: the word ahead wrote this byte at the same edge as our read
	assign info_cur = fwd_s1 ? fwd_data_s1 : mem_rd_data;
	assign info_new = info_cur & s1_q.write_data;

	always_ff @(posedge clk) begin
		if (s0_adv) begin
			s1_q        <= s1_d;
			idx_s1      <= s0_idx;
			fwd_s1      <= s1_adv && s1_q.info_wr && (idx_s1 == s0_idx);
			fwd_data_s1 <= info_new;
		end
	end

	// ---- output register ----
	logic [7:0]        rsp_read_data_q;
	logic              rsp_read_hit_q;
	logic              rsp_write_taken_q;
	nfcs_pkg::action_t rsp_action_q;
	logic [15:0]       rsp_action_address_q;
	logic [7:0]        rsp_action_data_q;
	logic              rsp_sequence_error_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_read_data_q      <= s1_q.info_rd ? info_cur : s1_q.read_data;
			rsp_read_hit_q       <= s1_q.read_hit;
			rsp_write_taken_q    <= s1_q.write_taken;
			rsp_action_q         <= s1_q.action;
			rsp_action_address_q <= s1_q.action_address;
			rsp_action_data_q    <= s1_q.action_data;
			rsp_sequence_error_q <= s1_q.sequence_error;
		end
	end

	assign rsp.valid          = rsp_v_q;
	assign rsp.read_data      = rsp_read_data_q;
	assign rsp.read_hit       = rsp_read_hit_q;
	assign rsp.write_taken    = rsp_write_taken_q;
	assign rsp.array_action   = rsp_action_q;
	assign rsp.action_address = rsp_action_address_q;
	assign rsp.action_data    = rsp_action_data_q;
	assign rsp.sequence_error = rsp_sequence_error_q;

	// ---- checks ----
	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !s0_adv)
		else $error("info RAM read during fill sweep");

	a_erase_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_q.erase) |=> mem_busy)
		else $error("info erase did not start a fill sweep");

	a_hit_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && rsp_read_hit_q) |->
			(!rsp_write_taken_q && (rsp_action_q == nfcs_pkg::ACT_NONE)))
		else $error("read hit on a write word");

	a_action_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && (rsp_action_q != nfcs_pkg::ACT_NONE)) |->
			(rsp_write_taken_q && !rsp_sequence_error_q))
		else $error("array action without a clean taken write");

endmodule

`default_nettype wire
